// ===== rtl/klock_pkg.sv =====
package klock_pkg;

	localparam int CODE_LENGTH_DEF = 4;

	localparam logic [3:0] DIG_BLANK = 4'd10;
	localparam logic [3:0] DIG_DASH  = 4'd11;
	localparam logic [3:0] KEY_NONE  = 4'd0;
	localparam logic [3:0] KEY_MAX   = 4'd9;

	localparam logic [7:0] LED_ALL_OFF = 8'hFF;
	localparam logic [7:0] LED_ALL_ON  = 8'h00;

	localparam logic [2:0] MODE_IDLE   = 3'd0;
	localparam logic [2:0] MODE_ENTER  = 3'd1;
	localparam logic [2:0] MODE_CHECK  = 3'd2;
	localparam logic [2:0] MODE_UNLOCK = 3'd3;
	localparam logic [2:0] MODE_ALARM  = 3'd4;

	localparam logic [2:0] CFG_SET_HOLD    = 3'd0;
	localparam logic [2:0] CFG_UNLOCK_TICK = 3'd1;
	localparam logic [2:0] CFG_UNLOCK_STEP = 3'd2;
	localparam logic [2:0] CFG_ALARM_TICK  = 3'd3;
	localparam logic [2:0] CFG_ALARM_STEP  = 3'd4;

	localparam logic [6:0] SET_HOLD_DEF    = 7'd100;
	localparam logic [6:0] UNLOCK_TICK_DEF = 7'd10;
	localparam logic [4:0] UNLOCK_STEP_DEF = 5'd28;
	localparam logic [6:0] ALARM_TICK_DEF  = 7'd20;
	localparam logic [4:0] ALARM_STEP_DEF  = 5'd6;

	localparam logic [4:0] BOUNCE_LEN = 5'd14;

	typedef struct packed {
		logic [6:0] set_hold_ticks;
		logic [6:0] unlock_step_ticks;
		logic [4:0] unlock_steps;
		logic [6:0] alarm_step_ticks;
		logic [4:0] alarm_steps;
	} cfg_t;

	typedef struct packed {
		logic [3:0] digit_0;
		logic [3:0] digit_1;
		logic [3:0] digit_2;
		logic [3:0] digit_3;
		logic [7:0] led_pattern;
		logic       relay_on;
		logic       buzzer_on;
		logic [2:0] lock_mode;
	} res_t;

	// bouncing single LED, step taken modulo the table length
	function automatic logic [7:0] bounce_led(input logic [4:0] step);
		logic [4:0] r;
		logic [7:0] v;
		if (step >= 5'd28) begin
			r = step - 5'd28;
		end else if (step >= BOUNCE_LEN) begin
			r = step - BOUNCE_LEN;
		end else begin
			r = step;
		end
		case (r[3:0])
			4'd0:  v = 8'hFE;
			4'd1:  v = 8'hFD;
			4'd2:  v = 8'hFB;
			4'd3:  v = 8'hF7;
			4'd4:  v = 8'hEF;
			4'd5:  v = 8'hDF;
			4'd6:  v = 8'hBF;
			4'd7:  v = 8'h7F;
			4'd8:  v = 8'hBF;
			4'd9:  v = 8'hDF;
			4'd10: v = 8'hEF;
			4'd11: v = 8'hF7;
			4'd12: v = 8'hFB;
			4'd13: v = 8'hFD;
			default: v = LED_ALL_OFF;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/keypad_code_lock_controller.sv =====
// Each accepted input item is held in the input register; its result is loaded into
// the output register when that is empty or m_tready is high, and is offered on m_tvalid.
// Throughput: one item per cycle while the output is not stalled; the lock state update is a single pass
// between the input register and the output register.
// Reset (arst_n low): state clears at once, config and lock registers return to defaults,
// display shows dashes, LEDs off, relay and buzzer off.
module keypad_code_lock_controller #(
	parameter int CODE_LENGTH = klock_pkg::CODE_LENGTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [3:0] key_code
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // digit_0, digit_1, digit_2, digit_3, led_pattern,
	                               // relay_on, buzzer_on, lock_mode
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [6:0]  cfg_data
);
	import klock_pkg::*;

	logic       vld_s1;
	logic [3:0] key_s1;
	logic       out_vld_q;
	logic [31:0] out_q;
	logic       adv;
	logic       take;
	logic [3:0] mbox;
	cfg_t       cfg_q;
	res_t       res;

	assign adv       = vld_s1 && (!out_vld_q || m_tready);
	assign s_tready  = !vld_s1 || adv;
	assign m_tvalid  = out_vld_q;
	assign m_tdata   = out_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.set_hold_ticks    <= SET_HOLD_DEF;
			cfg_q.unlock_step_ticks <= UNLOCK_TICK_DEF;
			cfg_q.unlock_steps      <= UNLOCK_STEP_DEF;
			cfg_q.alarm_step_ticks  <= ALARM_TICK_DEF;
			cfg_q.alarm_steps       <= ALARM_STEP_DEF;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SET_HOLD:    cfg_q.set_hold_ticks    <= cfg_data;
				CFG_UNLOCK_TICK: cfg_q.unlock_step_ticks <= cfg_data;
				CFG_UNLOCK_STEP: cfg_q.unlock_steps      <= cfg_data[4:0];
				CFG_ALARM_TICK:  cfg_q.alarm_step_ticks  <= cfg_data;
				CFG_ALARM_STEP:  cfg_q.alarm_steps       <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) vld_s1 <= 1'b1;
			else if (adv)             vld_s1 <= 1'b0;
			if (adv)           out_vld_q <= 1'b1;
			else if (m_tready) out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) key_s1 <= s_tdata[3:0];
		if (adv) begin
			out_q <= {3'b000, res.lock_mode, res.buzzer_on, res.relay_on, res.led_pattern,
				res.digit_3, res.digit_2, res.digit_1, res.digit_0};
		end
	end

	klock_qual u_qual (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.key    (key_s1),
		.take   (take),
		.mbox   (mbox)
	);

	klock_core #(
		.CODE_LENGTH (CODE_LENGTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.mbox   (mbox),
		.cfg    (cfg_q),
		.take   (take),
		.res    (res)
	);

endmodule

// ===== rtl/klock_qual.sv =====
module klock_qual (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  logic [3:0] key,
	input  logic       take,
	output logic [3:0] mbox
);
	import klock_pkg::*;

	typedef enum logic [2:0] {
		Q_WAIT = 3'b001,
		Q_SEEN = 3'b010,
		Q_HOLD = 3'b100
	} qst_t;

	qst_t       qst_q, qst_d;
	logic [3:0] mbox_q;
	logic [3:0] key_ok;
	logic       pressed;

	assign key_ok  = (key > KEY_MAX) ? KEY_NONE : key;
	assign pressed = (key_ok != KEY_NONE);

	always_comb begin
		qst_d = qst_q;
		mbox  = mbox_q;
		case (qst_q)
			Q_WAIT: begin
				if (pressed) qst_d = Q_SEEN;
			end
			Q_SEEN: begin
				if (pressed) begin
					qst_d = Q_HOLD;
					mbox  = key_ok;
				end else begin
					qst_d = Q_WAIT;
				end
			end
			Q_HOLD: begin
				if (!pressed) qst_d = Q_WAIT;
			end
			default: qst_d = Q_WAIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qst_q  <= Q_WAIT;
			mbox_q <= KEY_NONE;
		end else if (adv) begin
			qst_q  <= qst_d;
			mbox_q <= take ? KEY_NONE : mbox;
		end
	end

endmodule

// ===== rtl/klock_core.sv =====
module klock_core #(
	parameter int CODE_LENGTH = klock_pkg::CODE_LENGTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic [3:0]        mbox,
	input  klock_pkg::cfg_t   cfg,
	output logic              take,
	output klock_pkg::res_t   res
);
	import klock_pkg::*;

	localparam int IDX_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CODE_LENGTH - 1);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_ENTER  = 5'b00010,
		ST_CHECK  = 5'b00100,
		ST_UNLOCK = 5'b01000,
		ST_ALARM  = 5'b10000
	} st_t;

	st_t                         mode_q, mode_d;
	logic [IDX_W-1:0]            idx_q, idx_d, pidx;
	logic [CODE_LENGTH-1:0][3:0] ent_q, ent_d;
	logic [CODE_LENGTH-1:0][3:0] sto_q, sto_d;
	logic                        set_q, set_d;
	logic [6:0]                  tick_q, tick_d, tick_inc;
	logic [4:0]                  step_q, step_d, step_n;
	logic [7:0]                  led_q, led_d;
	logic                        relay_q, relay_d;
	logic                        buz_q, buz_d;
	logic [3:0]                  dig [4];

	assign tick_inc = tick_q + 7'd1;

	always_comb begin
		mode_d  = mode_q;
		idx_d   = idx_q;
		ent_d   = ent_q;
		sto_d   = sto_q;
		set_d   = set_q;
		tick_d  = tick_q;
		step_d  = step_q;
		step_n  = step_q;
		led_d   = led_q;
		relay_d = relay_q;
		buz_d   = buz_q;
		take    = 1'b0;
		pidx    = (mode_q == ST_IDLE) ? '0 : idx_q;
		case (mode_q)
			ST_IDLE, ST_ENTER: begin
				if (mode_q == ST_IDLE) ent_d = {CODE_LENGTH{DIG_DASH}};
				if (mbox != KEY_NONE) begin
					take        = 1'b1;
					ent_d[pidx] = mbox;
					if (pidx == IDX_LAST) begin
						idx_d  = '0;
						mode_d = ST_CHECK;
					end else begin
						idx_d  = pidx + IDX_W'(1);
						mode_d = ST_ENTER;
					end
				end
			end
			ST_CHECK: begin
				tick_d = tick_inc;
				if (!set_q) begin
					if (tick_inc == 7'd1) sto_d = ent_q;
					if (tick_inc >= cfg.set_hold_ticks) begin
						set_d  = 1'b1;
						mode_d = ST_IDLE;
						tick_d = '0;
						ent_d  = {CODE_LENGTH{DIG_DASH}};
					end
				end else begin
					tick_d = '0;
					mode_d = (ent_q == sto_q) ? ST_UNLOCK : ST_ALARM;
				end
			end
			ST_UNLOCK: begin
				ent_d = {CODE_LENGTH{DIG_BLANK}};
				if (step_q == '0 && tick_q == '0) begin
					relay_d = 1'b1;
					buz_d   = 1'b0;
				end
				tick_d = tick_inc;
				if (tick_inc >= cfg.unlock_step_ticks) begin
					tick_d = '0;
					led_d  = bounce_led(step_q);
					step_n = step_q + 5'd1;
				end
				step_d = step_n;
				if (step_n >= cfg.unlock_steps) begin
					step_d  = '0;
					relay_d = 1'b0;
					buz_d   = 1'b0;
					led_d   = LED_ALL_OFF;
					mode_d  = ST_IDLE;
				end
			end
			ST_ALARM: begin
				ent_d  = {CODE_LENGTH{DIG_BLANK}};
				tick_d = tick_inc;
				if (tick_inc >= cfg.alarm_step_ticks) begin
					tick_d = '0;
					if (!step_q[0]) begin
						led_d   = LED_ALL_ON;
						relay_d = 1'b0;
						buz_d   = 1'b1;
					end else begin
						led_d   = LED_ALL_OFF;
						relay_d = 1'b0;
						buz_d   = 1'b0;
					end
					step_n = step_q + 5'd1;
				end
				step_d = step_n;
				if (step_n >= cfg.alarm_steps) begin
					led_d   = LED_ALL_OFF;
					relay_d = 1'b0;
					buz_d   = 1'b0;
					step_d  = '0;
					mode_d  = ST_IDLE;
				end
			end
			default: mode_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= ST_IDLE;
			idx_q   <= '0;
			ent_q   <= {CODE_LENGTH{DIG_DASH}};
			sto_q   <= '0;
			set_q   <= 1'b0;
			tick_q  <= '0;
			step_q  <= '0;
			led_q   <= LED_ALL_OFF;
			relay_q <= 1'b0;
			buz_q   <= 1'b0;
		end else if (adv) begin
			mode_q  <= mode_d;
			idx_q   <= idx_d;
			ent_q   <= ent_d;
			sto_q   <= sto_d;
			set_q   <= set_d;
			tick_q  <= tick_d;
			step_q  <= step_d;
			led_q   <= led_d;
			relay_q <= relay_d;
			buz_q   <= buz_d;
		end
	end

	// result reflects the state after this item
	for (genvar j = 0; j < 4; j++) begin : g_dig
		if (j < CODE_LENGTH) begin : g_used
			assign dig[j] = ent_d[j];
		end else begin : g_blank
			assign dig[j] = DIG_BLANK;
		end
	end

	always_comb begin
		res.digit_0     = dig[0];
		res.digit_1     = dig[1];
		res.digit_2     = dig[2];
		res.digit_3     = dig[3];
		res.led_pattern = led_d;
		res.relay_on    = relay_d;
		res.buzzer_on   = buz_d;
		case (mode_d)
			ST_IDLE:   res.lock_mode = MODE_IDLE;
			ST_ENTER:  res.lock_mode = MODE_ENTER;
			ST_CHECK:  res.lock_mode = MODE_CHECK;
			ST_UNLOCK: res.lock_mode = MODE_UNLOCK;
			ST_ALARM:  res.lock_mode = MODE_ALARM;
			default:   res.lock_mode = MODE_IDLE;
		endcase
	end

	a_relay_buzzer_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(relay_q && buz_q))
		else $error("relay and buzzer both on");

	a_relay_in_unlock: assert property (@(posedge clk) disable iff (!arst_n)
		relay_q |-> (mode_q == ST_UNLOCK))
		else $error("relay on outside unlock");

	a_buzzer_in_alarm: assert property (@(posedge clk) disable iff (!arst_n)
		buz_q |-> (mode_q == ST_ALARM))
		else $error("buzzer on outside alarm");

	a_code_set_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(set_q))
		else $error("stored code lost");

endmodule
